FILE: rtl/signed_binary_to_decimal_ascii_assert.svh
// Assertion macros used by the checker file of the decimal converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Clocked property, switched off while reset is asserted.
`define SBDEC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("signed_binary_to_decimal_ascii: property violated");

// Condition that must hold whenever the output register shows a transaction.
`define SBDEC_ASSERT_OUT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (cond)) \
        else $error("signed_binary_to_decimal_ascii: bad output transaction");

`endif

FILE: rtl/sbdec_pkg.sv
// Package of the decimal converter: constants, character codes and state type.
package sbdec_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_DIGITS_DEF  = 19;

    // Number of magnitude bits folded into the BCD register per cycle.
    localparam int DABBLE_BITS = 4;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int BUF_W       = 7;

    localparam logic [BUF_W-1:0]  BUF_SIZE_RESET = 7'd21;
    localparam logic [BUF_W-1:0]  BUF_SIZE_MIN   = 7'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_SIGN,
        ST_DIGIT,
        ST_ERROR
    } state_t;

endpackage

FILE: rtl/sbdec_dabble.sv
// Double-dabble unit: shifts DABBLE_BITS binary bits into a packed BCD register.
module sbdec_dabble #(
    parameter int NUM_DIGITS = sbdec_pkg::MAX_DIGITS_DEF
) (
    input  logic [NUM_DIGITS*sbdec_pkg::DIGIT_W-1:0] bcd_in,
    input  logic [sbdec_pkg::DABBLE_BITS-1:0]        bits_in,
    output logic [NUM_DIGITS*sbdec_pkg::DIGIT_W-1:0] bcd_out,
    output logic                                     carry
);

    localparam int BCD_W = NUM_DIGITS * sbdec_pkg::DIGIT_W;

    logic [BCD_W-1:0]              acc;
    logic [sbdec_pkg::DIGIT_W-1:0] dig;
    logic                          lost;

    // Each pass adds three to every digit of five or more, then doubles the
    // whole register and brings in the next bit. A carry out of the top digit
    // means the value no longer fits in NUM_DIGITS digits.
    always_comb
    begin
        acc  = bcd_in;
        dig  = '0;
        lost = 1'b0;
        for (int s = sbdec_pkg::DABBLE_BITS - 1; s >= 0; s--)
        begin
            for (int j = 0; j < NUM_DIGITS; j++)
            begin
                dig = acc[j*sbdec_pkg::DIGIT_W +: sbdec_pkg::DIGIT_W];
                if (dig >= 4'd5)
                begin
                    dig = dig + 4'd3;
                end
                acc[j*sbdec_pkg::DIGIT_W +: sbdec_pkg::DIGIT_W] = dig;
            end
            lost = lost | acc[BCD_W-1];
            acc  = {acc[BCD_W-2:0], bits_in[s]};
        end
    end

    assign bcd_out = acc;
    assign carry   = lost;

endmodule

FILE: rtl/signed_binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
//
// Usage: one signed integer enters on the input channel (in_valid, in_stall,
// value). A transaction is accepted at a rising edge with in_valid high and
// in_stall low. The block then writes the decimal text of the value on the
// output channel (out_valid, out_stall, out_char, last, error), one character
// per transaction, most significant first: an optional '-', then the digits.
// last marks the final character. With buffer_size below two a single
// transaction with error set, last set and out_char zero is given instead.
// Sequence: after acceptance the magnitude is folded into BCD four bits per
// cycle, then the leading zeros of the kept window are skipped, then the
// characters follow one per cycle while the output is not stalled. When the
// number has more digits than the kept window (buffer_size - 1, at most
// MAX_DIGITS), only its low digits are written. in_stall stays high from
// acceptance until the last character or the error transaction is loaded,
// so a new value is not taken before then. A stall on the output holds the
// pending character in the output register and pauses the sequencer while
// it has a character to load. Reset returns to idle, clears the output valid
// and sets buffer_size to 21. The user must write configuration (cfg_we,
// cfg_data) only while the block is idle; the block does not enforce this.
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sbdec_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = sbdec_pkg::MAX_DIGITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sbdec_pkg::BUF_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [VALUE_WIDTH-1:0]       value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sbdec_pkg::CHAR_W-1:0]        out_char,
    output logic                                last,
    output logic                                error
);

    localparam int DW     = sbdec_pkg::DIGIT_W;
    localparam int STEPS  = (VALUE_WIDTH + sbdec_pkg::DABBLE_BITS - 1) / sbdec_pkg::DABBLE_BITS;
    localparam int PAD_W  = STEPS * sbdec_pkg::DABBLE_BITS;
    localparam int STEP_W = $clog2(STEPS);
    localparam int BCD_W  = MAX_DIGITS * DW;
    localparam int PTR_W  = $clog2(MAX_DIGITS);
    localparam int BW     = sbdec_pkg::BUF_W;

    // Control state.
    sbdec_pkg::state_t state_reg, state_next;
    logic [BW-1:0]     buf_size_reg;
    logic              out_valid_reg, out_valid_next;

    // Working registers of the current conversion.
    logic [PAD_W-1:0]  mag_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic              ovf_reg;
    logic              neg_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [STEP_W-1:0] step_reg;

    // Output register payload.
    logic [sbdec_pkg::CHAR_W-1:0] char_reg;
    logic                         last_reg;
    logic                         err_reg;

    logic                   accept;
    logic                   emit;
    logic                   slot_free;
    logic [sbdec_pkg::CHAR_W-1:0] emit_char;
    logic                   emit_last;
    logic                   emit_err;
    logic [DW-1:0]          cur_digit;
    logic                   skip_zero;
    logic                   above_nz;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [BW-1:0]          limit;
    logic [BCD_W-1:0]       dab_bcd;
    logic                   dab_carry;

    sbdec_dabble #(
        .NUM_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .bits_in (mag_reg[PAD_W-1 -: sbdec_pkg::DABBLE_BITS]),
        .bcd_out (dab_bcd),
        .carry   (dab_carry)
    );

    // The magnitude of the most negative value still fits unsigned in the
    // same width, so the negation needs no extra bit.
    assign mag_in = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

    // Digits kept: buffer_size - 1, capped by the BCD register depth.
    assign limit = ((buf_size_reg - BW'(1)) > BW'(MAX_DIGITS)) ?
                   BW'(MAX_DIGITS) : (buf_size_reg - BW'(1));

    assign cur_digit = bcd_reg[ptr_reg*DW +: DW];

    // Set when a nonzero digit lies above the kept window, that is when the
    // number has more digits than the buffer allows.
    always_comb
    begin
        above_nz = 1'b0;
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if ((BW'(j) >= limit) && (bcd_reg[j*DW +: DW] != '0))
            begin
                above_nz = 1'b1;
            end
        end
    end

    // Leading zeros of the kept window are dropped unless the value has more
    // digits than the window; then the kept low digits are written as they
    // stand.
    assign skip_zero = (ptr_reg != '0) && (cur_digit == '0) && !ovf_reg && !above_nz;

    assign slot_free = !out_valid_reg || !out_stall;
    assign accept    = in_valid && !in_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbdec_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (buf_size_reg < sbdec_pkg::BUF_SIZE_MIN)
                    begin
                        state_next = sbdec_pkg::ST_ERROR;
                    end
                    else
                    begin
                        state_next = sbdec_pkg::ST_CONVERT;
                    end
                end
            end
            sbdec_pkg::ST_CONVERT:
            begin
                if (step_reg == '0)
                begin
                    state_next = sbdec_pkg::ST_SCAN;
                end
            end
            sbdec_pkg::ST_SCAN:
            begin
                if (!skip_zero)
                begin
                    state_next = neg_reg ? sbdec_pkg::ST_SIGN : sbdec_pkg::ST_DIGIT;
                end
            end
            sbdec_pkg::ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = sbdec_pkg::ST_DIGIT;
                end
            end
            sbdec_pkg::ST_DIGIT:
            begin
                if (slot_free && (ptr_reg == '0))
                begin
                    state_next = sbdec_pkg::ST_IDLE;
                end
            end
            sbdec_pkg::ST_ERROR:
            begin
                if (slot_free)
                begin
                    state_next = sbdec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbdec_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: input stall and the character to load.
    always_comb
    begin
        in_stall  = (state_reg != sbdec_pkg::ST_IDLE);
        emit      = 1'b0;
        emit_char = sbdec_pkg::CHAR_NONE;
        emit_last = 1'b0;
        emit_err  = 1'b0;
        case (state_reg)
            sbdec_pkg::ST_SIGN:
            begin
                emit      = slot_free;
                emit_char = sbdec_pkg::CHAR_MINUS;
            end
            sbdec_pkg::ST_DIGIT:
            begin
                emit      = slot_free;
                emit_char = sbdec_pkg::CHAR_ZERO + sbdec_pkg::CHAR_W'(cur_digit);
                emit_last = (ptr_reg == '0);
            end
            sbdec_pkg::ST_ERROR:
            begin
                emit      = slot_free;
                emit_char = sbdec_pkg::CHAR_NONE;
                emit_last = 1'b1;
                emit_err  = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // A transaction stays in the output register until it is taken.
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbdec_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            buf_size_reg  <= sbdec_pkg::BUF_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                buf_size_reg <= cfg_data;
            end
        end
    end

    // Datapath registers; only the control registers need a reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg  <= PAD_W'(mag_in);
            bcd_reg  <= '0;
            ovf_reg  <= 1'b0;
            neg_reg  <= value[VALUE_WIDTH-1];
            ptr_reg  <= PTR_W'(limit - BW'(1));
            step_reg <= STEP_W'(STEPS - 1);
        end
        else if (state_reg == sbdec_pkg::ST_CONVERT)
        begin
            mag_reg  <= mag_reg << sbdec_pkg::DABBLE_BITS;
            bcd_reg  <= dab_bcd;
            ovf_reg  <= ovf_reg | dab_carry;
            step_reg <= step_reg - STEP_W'(1);
        end
        else if ((state_reg == sbdec_pkg::ST_SCAN) && skip_zero)
        begin
            ptr_reg <= ptr_reg - PTR_W'(1);
        end
        else if ((state_reg == sbdec_pkg::ST_DIGIT) && emit && (ptr_reg != '0))
        begin
            ptr_reg <= ptr_reg - PTR_W'(1);
        end

        if (emit)
        begin
            char_reg <= emit_char;
            last_reg <= emit_last;
            err_reg  <= emit_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign last      = last_reg;
    assign error     = err_reg;

endmodule

FILE: rtl/sbdec_checker.sv
// Port-level checker of the decimal converter and its bind to the top level.
`include "signed_binary_to_decimal_ascii_assert.svh"

module sbdec_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [sbdec_pkg::CHAR_W-1:0] out_char,
    input logic                         last,
    input logic                         error
);

    // A stalled output transaction keeps its payload.
    `SBDEC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last) && $stable(error))

    // One conversion at a time: the input closes right after a transaction.
    `SBDEC_ASSERT(a_in_busy, in_valid && !in_stall |=> in_stall)

    // An error transaction is alone, carries no text and ends the conversion.
    `SBDEC_ASSERT_OUT(a_err_form, !error || (last && (out_char == sbdec_pkg::CHAR_NONE)))

    // Text is a minus sign that never ends the text, or a decimal digit.
    `SBDEC_ASSERT_OUT(a_char_set, error || (out_char == sbdec_pkg::CHAR_MINUS && !last) || (out_char >= sbdec_pkg::CHAR_ZERO && out_char <= sbdec_pkg::CHAR_NINE))

endmodule

bind signed_binary_to_decimal_ascii sbdec_checker u_sbdec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last),
    .error     (error)
);
